FILE: sv/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
`timescale 1ns / 1ps

package bdq_pkg;

  // Value and configuration widths
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  // Operation codes carried on the kind port
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_STATUS     = 3'd4
  } kind_t;

  // Value reported for an empty end or a missing pop
  localparam logic signed [VAL_W-1:0] NEG_ONE = '1;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

FILE: sv/bounded_double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values on a circular slot memory.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive kind and push_value with start high; the beat is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with op_ok,
//   popped_value, front_value, rear_value, is_empty, is_full and entry_count.
//   The receiver cannot stall; every result must be captured in that cycle.
//   Configuration: cfg_we writes cfg_data into the capacity register at the
//   edge; write it only while no command is in flight.
// Command flow:
//   Push, status and pops on an empty queue: result in the cycle after accept,
//   next command taken in the following cycle.
//   Pops that remove data: the block is busy in ST_FETCH while the new end
//   value is fetched from the slot memory through its registered read port.
//   Front and rear values sit in registers, so only pops touch the read port.
// Reset (rst, synchronous): queue empty, capacity 16, no result pending.
//   Slot contents stay undefined; only written slots are ever reported.
module bounded_double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        kind,
  input  logic signed [bdq_pkg::VAL_W-1:0]  push_value,
  input  logic                              cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]         cfg_data,
  output logic                              done,
  output logic                              op_ok,
  output logic signed [bdq_pkg::VAL_W-1:0]  popped_value,
  output logic signed [bdq_pkg::VAL_W-1:0]  front_value,
  output logic signed [bdq_pkg::VAL_W-1:0]  rear_value,
  output logic                              is_empty,
  output logic                              is_full,
  output logic [bdq_pkg::CAP_W-1:0]         entry_count
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > bdq_pkg::CAP_W) ? CNT_W : bdq_pkg::CAP_W;
  localparam logic [AW-1:0]    LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

  // Circular index steps
  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  state_t                            state;
  logic [AW-1:0]                     head;
  logic [AW-1:0]                     tail;
  logic [CNT_W-1:0]                  count;
  logic [bdq_pkg::CAP_W-1:0]         cap;
  logic signed [bdq_pkg::VAL_W-1:0]  front_val;
  logic signed [bdq_pkg::VAL_W-1:0]  rear_val;
  logic                              fetch_front;

  // Slot memory and its registered read data
  logic signed [bdq_pkg::VAL_W-1:0]  mem [DEPTH];
  logic signed [bdq_pkg::VAL_W-1:0]  rd_data;

  logic                              accept;
  logic [CMP_W-1:0]                  cap_eff;
  logic                              full_now;
  logic                              empty_now;

  logic [AW-1:0]                     head_next;
  logic [AW-1:0]                     tail_next;
  logic [CNT_W-1:0]                  count_next;
  logic signed [bdq_pkg::VAL_W-1:0]  front_next;
  logic signed [bdq_pkg::VAL_W-1:0]  rear_next;
  logic signed [bdq_pkg::VAL_W-1:0]  popped_c;
  logic                              ok_c;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic                              fetch_front_next;

  logic signed [bdq_pkg::VAL_W-1:0]  fetch_front_val;
  logic signed [bdq_pkg::VAL_W-1:0]  fetch_rear_val;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Saturate the capacity at the slot count
  assign cap_eff   = (CMP_W'(cap) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(cap);
  assign full_now  = (CMP_W'(count) >= cap_eff);
  assign empty_now = (count == '0);

  // Decode the command and form the next pointers, count and end values
  always_comb begin
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    front_next       = front_val;
    rear_next        = rear_val;
    popped_c         = bdq_pkg::NEG_ONE;
    ok_c             = 1'b1;
    wr_en            = 1'b0;
    wr_addr          = tail;
    rd_en            = 1'b0;
    rd_addr          = head;
    fetch_front_next = fetch_front;
    case (kind)
      bdq_pkg::KIND_PUSH_FRONT: begin
        if (full_now) begin
          ok_c = 1'b0;
        end else begin
          head_next  = idx_dec(head);
          wr_en      = 1'b1;
          wr_addr    = idx_dec(head);
          count_next = count + CNT_W'(1);
          front_next = push_value;
          if (empty_now) begin
            rear_next = push_value;
          end
        end
      end
      bdq_pkg::KIND_PUSH_REAR: begin
        if (full_now) begin
          ok_c = 1'b0;
        end else begin
          tail_next  = idx_inc(tail);
          wr_en      = 1'b1;
          wr_addr    = tail;
          count_next = count + CNT_W'(1);
          rear_next  = push_value;
          if (empty_now) begin
            front_next = push_value;
          end
        end
      end
      bdq_pkg::KIND_POP_FRONT: begin
        if (empty_now) begin
          ok_c = 1'b0;
        end else begin
          popped_c         = front_val;
          head_next        = idx_inc(head);
          count_next       = count - CNT_W'(1);
          rd_en            = 1'b1;
          rd_addr          = idx_inc(head);
          fetch_front_next = 1'b1;
        end
      end
      bdq_pkg::KIND_POP_REAR: begin
        if (empty_now) begin
          ok_c = 1'b0;
        end else begin
          popped_c         = rear_val;
          tail_next        = idx_dec(tail);
          count_next       = count - CNT_W'(1);
          rd_en            = 1'b1;
          rd_addr          = idx_dec(idx_dec(tail));
          fetch_front_next = 1'b0;
        end
      end
      default: begin
        // status only, and unused codes behave the same
      end
    endcase
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= push_value;
    end
    if (accept && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Merge the fetched slot into the end that moved
  assign fetch_front_val = fetch_front ? rd_data : front_val;
  assign fetch_rear_val  = fetch_front ? rear_val : rd_data;

  // Hold state, pointers, end values and the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      cap   <= bdq_pkg::CAP_RESET;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        cap <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            head         <= head_next;
            tail         <= tail_next;
            count        <= count_next;
            front_val    <= front_next;
            rear_val     <= rear_next;
            fetch_front  <= fetch_front_next;
            op_ok        <= ok_c;
            popped_value <= popped_c;
            if (rd_en) begin
              state <= ST_FETCH;
            end else begin
              done        <= 1'b1;
              front_value <= (count_next == '0) ? bdq_pkg::NEG_ONE : front_next;
              rear_value  <= (count_next == '0) ? bdq_pkg::NEG_ONE : rear_next;
              is_empty    <= (count_next == '0);
              is_full     <= (CMP_W'(count_next) >= cap_eff);
              entry_count <= bdq_pkg::CAP_W'(count_next);
            end
          end
        end
        ST_FETCH: begin
          // Drop the fetched value in and emit the beat
          state       <= ST_IDLE;
          front_val   <= fetch_front_val;
          rear_val    <= fetch_rear_val;
          done        <= 1'b1;
          front_value <= empty_now ? bdq_pkg::NEG_ONE : fetch_front_val;
          rear_value  <= empty_now ? bdq_pkg::NEG_ONE : fetch_rear_val;
          is_empty    <= empty_now;
          is_full     <= full_now;
          entry_count <= bdq_pkg::CAP_W'(count);
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The count never passes the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= DEPTH_CMP)
    else $error("queue count exceeds slot count");

  // A fetch returns to idle in the next cycle and ends in a result beat
  a_fetch_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |=> (state == ST_IDLE) && done)
    else $error("fetch did not finish in one cycle");

  // Every accepted command either reports at once or enters a fetch
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || state == ST_FETCH))
    else $error("accepted command produced no progress");

  // An empty queue reports -1 at both ends
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |->
      (front_value == bdq_pkg::NEG_ONE) && (rear_value == bdq_pkg::NEG_ONE))
    else $error("empty queue reported a value at an end");

endmodule
